// ===== src/lcdtr_pkg.sv =====
// Shared types, constants and the 5x7 font table of the LCD text character renderer.
package lcdtr_pkg;

  localparam int CHARS_PER_ROW = 22;
  localparam int GLYPH_COLUMNS = 5;
  localparam int ROW_W = 3;
  localparam int COL_W = 5;
  localparam int POS_W = 8;
  localparam int GIDX_W = 7;
  localparam int FONT_COUNT = 95;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;
  localparam int STEP_W = 3;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(CHARS_PER_ROW - 1);
  localparam logic [7:0] FONT_FIRST = 8'h20;
  localparam logic [7:0] FONT_LAST = 8'h7E;
  localparam logic [7:0] PAGE_SET_BASE = 8'hB0;
  localparam logic [7:0] COL_HI_BASE = 8'h10;
  localparam logic [7:0] CURSOR_BIT = 8'h80;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_CURSOR_ENABLE = 2'd0;
  localparam logic [1:0] REG_CURSOR_ROW = 2'd1;
  localparam logic [1:0] REG_CURSOR_COL = 2'd2;

  // Input command codes.
  localparam logic CMD_SET_POS = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // Byte sequence of one character.
  localparam logic [STEP_W-1:0] STEP_PAGE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_COL_HI = 3'd1;
  localparam logic [STEP_W-1:0] STEP_COL_LO = 3'd2;
  localparam logic [STEP_W-1:0] STEP_GLYPH0 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_GLYPH1 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_GLYPH2 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_GLYPH3 = 3'd6;
  localparam logic [STEP_W-1:0] STEP_GLYPH4 = 3'd7;

  typedef struct packed {
    logic               cursor_enable;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
  } cfg_t;

  // One character job handed from the front end to the byte sequencer.
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [POS_W-1:0]   pos;
    logic [GIDX_W-1:0]  gidx;
    logic               mark;
  } job_t;

  // Five column bytes per glyph, first column in the top byte.
  localparam logic [39:0] FONT_ROM [FONT_COUNT] = '{
    40'h0000000000, 40'h00004f0000, 40'h0007000700,
    40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001c224100,
    40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
    40'h4261514946, 40'h2141454b31, 40'h1814127f10,
    40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e,
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
    40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
    40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
    40'h2649494932, 40'h01017f0101, 40'h3f4040403f,
    40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7f48444438, 40'h3844444420, 40'h384444487f,
    40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00047d0000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c0418047c,
    40'h7c08040478, 40'h3844444438, 40'h7c14141408,
    40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
    40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h0000770000,
    40'h0041360800, 40'h0804081008
  };

endpackage

// ===== src/lcdtr_front.sv =====
// Front end: accepts input words, tracks the text position and queues character jobs.
module lcdtr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcdtr_pkg::cfg_t             cfg,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [lcdtr_pkg::ROW_W-1:0] in_row,
  input  logic [lcdtr_pkg::COL_W-1:0] in_col,
  input  logic [7:0]                  in_char_code,
  output logic                        push,
  output lcdtr_pkg::job_t             push_job
);

  logic [lcdtr_pkg::ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [lcdtr_pkg::COL_W-1:0] cur_col_r, cur_col_nxt;
  logic                        accept;
  logic [7:0]                  code_off;
  logic                        in_font;

  assign accept   = in_valid & ~in_stall;
  assign push     = accept & (in_cmd == lcdtr_pkg::CMD_RENDER);
  assign code_off = in_char_code - lcdtr_pkg::FONT_FIRST;
  assign in_font  = (in_char_code >= lcdtr_pkg::FONT_FIRST) &&
                    (in_char_code <= lcdtr_pkg::FONT_LAST);

  always_comb begin
    push_job.row  = cur_row_r;
    // Column address of the glyph: six pixels per character plus a four pixel margin.
    push_job.pos  = ({3'b000, cur_col_r} << 2) + ({3'b000, cur_col_r} << 1) + 8'd4;
    // Codes outside the font use the blank space glyph at index zero.
    push_job.gidx = in_font ? code_off[lcdtr_pkg::GIDX_W-1:0] : '0;
    push_job.mark = cfg.cursor_enable && (cur_row_r == cfg.cursor_row) &&
                    (cur_col_r == cfg.cursor_col);
  end

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (accept) begin
      if (in_cmd == lcdtr_pkg::CMD_SET_POS) begin
        cur_row_nxt = in_row;
        cur_col_nxt = (in_col > lcdtr_pkg::LAST_COL) ? lcdtr_pkg::LAST_COL : in_col;
      end else if (cur_col_r == lcdtr_pkg::LAST_COL) begin
        cur_col_nxt = '0;
        cur_row_nxt = cur_row_r + 3'd1;
      end else begin
        cur_col_nxt = cur_col_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

endmodule

// ===== src/lcdtr_fifo.sv =====
// Short job queue between the front end and the byte sequencer.
module lcdtr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcdtr_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lcdtr_pkg::job_t head_job
);

  lcdtr_pkg::job_t                  mem_r [lcdtr_pkg::FIFO_DEPTH];
  logic [lcdtr_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lcdtr_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lcdtr_pkg::FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == lcdtr_pkg::FIFO_CNT_W'(lcdtr_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/lcdtr_back.sv =====
// Byte sequencer: turns one queued character job into eight bus words.
module lcdtr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_avail,
  input  lcdtr_pkg::job_t head_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_lcd_byte,
  output logic            out_is_data,
  output logic            out_last_of_run
);

  lcdtr_pkg::job_t                  job_r, job_nxt;
  logic                             job_valid_r, job_valid_nxt;
  logic [lcdtr_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [7:0]                       byte_r, byte_nxt;
  logic                             data_r, data_nxt;
  logic                             last_r, last_nxt;
  logic                             advance;
  logic                             need_job;
  logic [39:0]                      glyph;
  logic [7:0]                       seq_byte;

  assign advance  = ~out_valid_r | ~out_stall;
  assign need_job = ~job_valid_r |
                    (advance & (step_r == lcdtr_pkg::STEP_GLYPH4));
  assign pop      = need_job & job_avail;
  assign glyph    = lcdtr_pkg::FONT_ROM[job_r.gidx];

  always_comb begin
    unique case (step_r)
      lcdtr_pkg::STEP_PAGE:   seq_byte = lcdtr_pkg::PAGE_SET_BASE + {5'b00000, job_r.row};
      lcdtr_pkg::STEP_COL_HI: seq_byte = lcdtr_pkg::COL_HI_BASE + {4'b0000, job_r.pos[7:4]};
      lcdtr_pkg::STEP_COL_LO: seq_byte = {4'b0000, job_r.pos[3:0]};
      lcdtr_pkg::STEP_GLYPH0: seq_byte = {job_r.mark, glyph[38:32]};
      lcdtr_pkg::STEP_GLYPH1: seq_byte = {job_r.mark, glyph[30:24]};
      lcdtr_pkg::STEP_GLYPH2: seq_byte = {job_r.mark, glyph[22:16]};
      lcdtr_pkg::STEP_GLYPH3: seq_byte = {job_r.mark, glyph[14:8]};
      lcdtr_pkg::STEP_GLYPH4: seq_byte = {job_r.mark, glyph[6:0]};
      default:                seq_byte = '0;
    endcase
  end

  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = job_valid_r;
      if (job_valid_r) begin
        byte_nxt = seq_byte;
        data_nxt = (step_r >= lcdtr_pkg::STEP_GLYPH0);
        last_nxt = (step_r == lcdtr_pkg::STEP_GLYPH4);
        step_nxt = step_r + 3'd1;
      end
    end
    if (need_job) begin
      job_valid_nxt = job_avail;
      job_nxt       = head_job;
      step_nxt      = lcdtr_pkg::STEP_PAGE;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    byte_r <= byte_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      step_r      <= lcdtr_pkg::STEP_PAGE;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lcd_byte    = byte_r;
  assign out_is_data     = data_r;
  assign out_last_of_run = last_r;

endmodule

// ===== src/lcd_text_char_renderer_core.sv =====
// Top level of the LCD text character renderer: configuration registers and block wiring.
//
// Usage: words on the input channel either set the text position (cmd 0, row and col)
// or render one character (cmd 1, char_code). A set-position word produces no output.
// A render word produces eight output words: page set, column high and column low
// command bytes, then the five font column bytes of the glyph, the last one flagged
// by out_last_of_run. Bit 7 of each data byte marks the cursor position when enabled.
// After each character the column advances, wrapping to the next page row at 22.
// Both channels use valid/stall: a word moves when valid is high and stall is low.
// A render word reaches the output through the job queue, the job register and the
// output register. Throughput: one output word per cycle while jobs are queued and the
// receiver does not stall; the byte sequencer sets this rate. A two-entry job queue
// lets the front end keep taking words while the sequencer works; in_stall rises
// only when that queue is full, and then holds set-position words back as well.
// When the receiver stalls, the output register holds its word and the sequencer
// pauses; the queue then fills and stalls the input. Reset clears the text position,
// the cursor registers, the queue and the output valid flag; no clearing pass is needed.
// Configuration registers sit at byte addresses 0 (cursor enable), 4 (cursor row)
// and 8 (cursor column) and should be written only while the block is idle.
module lcd_text_char_renderer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [lcdtr_pkg::ROW_W-1:0] in_row,
  input  logic [lcdtr_pkg::COL_W-1:0] in_col,
  input  logic [7:0]                  in_char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_lcd_byte,
  output logic                        out_is_data,
  output logic                        out_last_of_run
);

  lcdtr_pkg::cfg_t cfg_r, cfg_nxt;
  logic            cfg_write;
  logic            push;
  logic            pop;
  logic            fifo_full;
  logic            fifo_not_empty;
  lcdtr_pkg::job_t push_job;
  lcdtr_pkg::job_t head_job;

  // The bus never waits; a write lands at the end of the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (paddr[3:2])
        lcdtr_pkg::REG_CURSOR_ENABLE: cfg_nxt.cursor_enable = pwdata[0];
        lcdtr_pkg::REG_CURSOR_ROW:    cfg_nxt.cursor_row = pwdata[lcdtr_pkg::ROW_W-1:0];
        lcdtr_pkg::REG_CURSOR_COL:    cfg_nxt.cursor_col = pwdata[lcdtr_pkg::COL_W-1:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lcdtr_pkg::REG_CURSOR_ENABLE: prdata = {31'd0, cfg_r.cursor_enable};
      lcdtr_pkg::REG_CURSOR_ROW:    prdata = {29'd0, cfg_r.cursor_row};
      lcdtr_pkg::REG_CURSOR_COL:    prdata = {27'd0, cfg_r.cursor_col};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The input waits only while the job queue is full.
  assign in_stall = fifo_full;

  lcdtr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_char_code (in_char_code),
    .push         (push),
    .push_job     (push_job)
  );

  lcdtr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (fifo_full),
    .not_empty (fifo_not_empty),
    .head_job  (head_job)
  );

  lcdtr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_avail       (fifo_not_empty),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lcd_byte    (out_lcd_byte),
    .out_is_data     (out_is_data),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the LCD text character renderer core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to let pass before a register write once the last byte is out.
  localparam int SETTLE_CYCLES = 10;
  // A register index the block does not decode; writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 50;

  // Our own copy of the 5x7 font, codes 0x20 to 0x7E, first column in the top byte.
  localparam logic [39:0] GLYPHS [95] = '{
    40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h2649494932, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00047d0000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c0418047c, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h0000770000, 40'h0041360800, 40'h0804081008
  };

  typedef logic [lcdtr_pkg::ROW_W-1:0] row_t;
  typedef logic [lcdtr_pkg::COL_W-1:0] col_t;

  // One input word: a set-position or a render request.
  typedef struct packed {
    logic       cmd;
    row_t       row;
    col_t       col;
    logic [7:0] char_code;
  } text_word_t;

  // One bus byte as it leaves the block.
  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last_of_run;
  } bus_byte_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  row_t        in_row = '0;
  col_t        in_col = '0;
  logic [7:0]  in_char_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_lcd_byte;
  logic        out_is_data;
  logic        out_last_of_run;

  // Words waiting to be offered, and bytes the block still owes us.
  text_word_t pending_words[$];
  bus_byte_t  owed_bytes[$];

  // Predictor state: text position and the cursor registers as last written.
  row_t text_row = '0;
  col_t text_col = '0;
  logic cursor_on = 1'b0;
  row_t cursor_at_row = '0;
  col_t cursor_at_col = '0;

  int fail_count = 0;
  int bytes_seen = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int seg_left = 0;
  stall_mode_t seg_mode = STALL_NONE;

  lcd_text_char_renderer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_row(in_row),
    .in_col(in_col), .in_char_code(in_char_code),
    .out_valid(out_valid), .out_stall(out_stall), .out_lcd_byte(out_lcd_byte),
    .out_is_data(out_is_data), .out_last_of_run(out_last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out what one accepted word produces and advances the text position.
  // A set-position word only moves the position, with the column clamped to the
  // last one on the line. A render word owes three command bytes and five glyph
  // bytes; codes outside the printable range draw a blank glyph.
  task automatic track_text_word(input text_word_t w);
    int pos;
    logic [7:0] mark;
    logic [7:0] column_bits;
    bit printable;
    if (w.cmd == lcdtr_pkg::CMD_SET_POS) begin
      text_row = w.row;
      text_col = (w.col >= col_t'(lcdtr_pkg::CHARS_PER_ROW)) ?
                 col_t'(lcdtr_pkg::CHARS_PER_ROW - 1) : w.col;
    end else begin
      pos = int'(text_col) * 6 + 4;
      owed_bytes.push_back('{8'hB0 + 8'(text_row), 1'b0, 1'b0});
      owed_bytes.push_back('{8'h10 + 8'(pos >> 4), 1'b0, 1'b0});
      owed_bytes.push_back('{8'(pos & 'h0F), 1'b0, 1'b0});
      // The cursor bit goes into every column byte of the character under the cursor.
      mark = (cursor_on && text_row == cursor_at_row && text_col == cursor_at_col) ?
             8'h80 : 8'h00;
      printable = (w.char_code >= 8'h20) && (w.char_code <= 8'h7E);
      for (int i = 0; i < lcdtr_pkg::GLYPH_COLUMNS; i++) begin
        column_bits = printable ? GLYPHS[w.char_code - 8'h20][39 - 8*i -: 8] : 8'h00;
        owed_bytes.push_back('{column_bits | mark, 1'b1,
                               1'(i == lcdtr_pkg::GLYPH_COLUMNS - 1)});
      end
      // Advance the column; the end of a line wraps to the next page row,
      // and the last page row wraps to the top.
      if (text_col == col_t'(lcdtr_pkg::CHARS_PER_ROW - 1)) begin
        text_col = '0;
        text_row = text_row + 1'b1;
      end else begin
        text_col = text_col + 1'b1;
      end
    end
  endtask

  task automatic add_set_pos(input int row, input int col);
    pending_words.push_back('{lcdtr_pkg::CMD_SET_POS, row_t'(row), col_t'(col), 8'($urandom)});
  endtask

  task automatic add_char(input int code);
    pending_words.push_back('{lcdtr_pkg::CMD_RENDER, row_t'($urandom), col_t'($urandom),
                              8'(code)});
  endtask

  // Random traffic: mostly characters, some position loads. Many loads land on
  // or just ahead of the cursor so that marked characters come up often.
  task automatic add_random_words(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        add_char(($urandom_range(0, 9) < 7) ? $urandom_range(8'h20, 8'h7E) :
                 $urandom_range(0, 255));
      end else if (pick < 85) begin
        add_set_pos(cursor_at_row, cursor_at_col);
      end else if (pick < 90) begin
        add_set_pos(cursor_at_row, (cursor_at_col == 0) ? 0 : cursor_at_col - 1);
      end else begin
        add_set_pos($urandom_range(0, 7), $urandom_range(0, 31));
      end
    end
  endtask

  // Waits until every word has gone in and every owed byte has come out, then
  // a little longer so that a trailing set-position word has settled too.
  task automatic wait_until_idle();
    while (pending_words.size() != 0 || in_valid || owed_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup cycle, then an access cycle. The register takes
  // the value at the edge that ends the access cycle, since pready is always high.
  task automatic write_cursor_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lcdtr_pkg::REG_CURSOR_ENABLE: cursor_on = value[0];
      lcdtr_pkg::REG_CURSOR_ROW: cursor_at_row = value[lcdtr_pkg::ROW_W-1:0];
      lcdtr_pkg::REG_CURSOR_COL: cursor_at_col = value[lcdtr_pkg::COL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cursor(input int enable, input int row, input int col);
    write_cursor_reg(lcdtr_pkg::REG_CURSOR_ENABLE, 32'(enable));
    write_cursor_reg(lcdtr_pkg::REG_CURSOR_ROW, 32'(row));
    write_cursor_reg(lcdtr_pkg::REG_CURSOR_COL, 32'(col));
  endtask

  // Input driver. It offers words from the pending queue in bursts of random
  // length with random gaps, and holds a word steady while the block stalls it.
  // The prediction is made at the edge that accepts the word.
  always @(posedge clk) begin
    text_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        track_text_word('{in_cmd, in_row, in_col, in_char_code});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_cmd <= w.cmd;
          in_row <= w.row;
          in_col <= w.col;
          in_char_code <= w.char_code;
          in_valid <= 1'b1;
          // At the end of a burst pick the next one; a third of the time there
          // is no gap at all, so long back-to-back stretches happen too.
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. It runs through segments of random length, each with its own
  // pattern: no stall, light, heavy or toggling. Twice in the run it holds off
  // while the sender keeps offering words, so the job queue fills and the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && bytes_seen >= ((holds_done == 0) ? 200 : 1600)) begin
      hold_left <= 400;
      holds_done <= holds_done + 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 80);
        seg_mode = stall_mode_t'($urandom_range(0, 3));
      end else begin
        seg_left--;
      end
      case (seg_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= !out_stall;
      endcase
    end
  end

  // Output checker: every accepted byte is compared with the oldest one owed.
  always @(posedge clk) begin
    bus_byte_t owed;
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (owed_bytes.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected output word: byte %02h data %0b last %0b",
                   out_lcd_byte, out_is_data, out_last_of_run);
        fail_count++;
      end else begin
        owed = owed_bytes.pop_front();
        if (out_lcd_byte !== owed.lcd_byte || out_is_data !== owed.is_data ||
            out_last_of_run !== owed.last_of_run) begin
          if (fail_count < 10)
            $display({"mismatch on output word %0d: expected byte %02h data %0b last %0b,",
                      " got byte %02h data %0b last %0b"},
                     bytes_seen, owed.lcd_byte, owed.is_data, owed.last_of_run,
                     out_lcd_byte, out_is_data, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed",
               cycle_count, owed_bytes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words with the cursor off: printable extremes, codes below and
    // above the font, a wrap from the last column of the last row to the top,
    // and column loads past the end of a line, which clamp to the last column.
    add_set_pos(0, 0);
    add_char(8'h20);
    add_char(8'h7E);
    add_char(8'h00);
    add_char(8'hFF);
    add_char(8'h1F);
    add_char(8'h7F);
    add_char(8'h41);
    add_set_pos(7, 21);
    add_char(8'h5A);
    add_char(8'h61);
    add_set_pos(2, 31);
    add_char(8'h30);
    add_set_pos(4, 22);
    add_char(8'h21);
    wait_until_idle();

    // Cursor at the bottom right corner. A write to an undecoded register
    // must leave the cursor settings alone.
    set_cursor(1, 7, 21);
    write_cursor_reg(REG_UNUSED, 32'hFFFF_FFFF);
    add_set_pos(7, 20);
    add_char(8'h78);
    add_char(8'h79);
    add_char(8'h7A);
    add_set_pos(7, 31);
    add_char(8'h00);
    add_set_pos(7, 25);
    add_char(8'hFF);
    wait_until_idle();

    // Random phases, each under its own cursor setting: the corners, the cursor
    // switched off, a cursor column past the line end that never matches, and
    // random spots.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_cursor(1, 0, 0);
        1: set_cursor(0, 7, 21);
        2: set_cursor(1, $urandom_range(0, 7), $urandom_range(22, 31));
        3: set_cursor(1, 7, 21);
        default: set_cursor(1, $urandom_range(0, 7), $urandom_range(0, 21));
      endcase
      add_random_words(WORDS_PER_PHASE);
      wait_until_idle();
    end

    // Whatever is still owed now never arrived.
    if (owed_bytes.size() != 0) begin
      $display("%0d output words never arrived", owed_bytes.size());
      fail_count += owed_bytes.size();
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lcdtr_pkg.sv
src/lcdtr_front.sv
src/lcdtr_fifo.sv
src/lcdtr_back.sv
src/lcd_text_char_renderer_core.sv
tb/tb.sv
